// ===== src/prja_pkg.sv =====
// Shared types, codes and constants of the promotion-revenue join/aggregate block.
`timescale 1ns / 1ps

package prja_pkg;

    localparam int DEFAULT_PART_KEYS = 262144;

    // action codes (s_tuser)
    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_LINE   = 2'd1;
    localparam logic [1:0] ACT_FINISH = 2'd2;
    localparam logic [1:0] ACT_SKIP   = 2'd3;

    // status codes (m_tuser)
    localparam logic [2:0] ST_COUNTED    = 3'd0;
    localparam logic [2:0] ST_WINDOW     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN    = 3'd2;
    localparam logic [2:0] ST_LOAD_RANGE = 3'd3;
    localparam logic [2:0] ST_REPORT     = 3'd4;

    // config register indexes
    localparam int         CFG_IDX_W         = 1;
    localparam int         CFG_DATA_W        = 16;
    localparam logic [0:0] REG_WINDOW_START  = 1'b0;
    localparam logic [0:0] REG_WINDOW_END    = 1'b1;

    // input word layout
    localparam int KEY_W      = 32;
    localparam int PREFIX_W   = 40;
    localparam int DAY_W      = 16;
    localparam int PRICE_W    = 31;
    localparam int KEY_LSB    = 0;
    localparam int PREFIX_LSB = KEY_LSB + KEY_W;
    localparam int DAY_LSB    = PREFIX_LSB + PREFIX_W;
    localparam int PRICE_LSB  = DAY_LSB + DAY_W;
    localparam int IN_BITS    = PRICE_LSB + PRICE_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

    // output word layout
    localparam int PCT_W       = 14;
    localparam int SUM_W       = 63;
    localparam int OUT_BITS    = PCT_W + 2 * SUM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [PREFIX_W-1:0] PROMO_WORD = 40'h50524F4D4F;
    localparam logic [SUM_W-1:0]    SUM_MAX    = {SUM_W{1'b1}};

    // key table entry bits
    localparam int ENTRY_VALID_BIT = 0;
    localparam int ENTRY_PROMO_BIT = 1;

    // share = round(PCT_SCALE * promo / total)
    localparam int PCT_SCALE  = 10000;
    localparam int DVD_W      = SUM_W + PCT_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic mul_go;
        logic div_step;
        logic round_go;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic total_zero;
        logic out_free;
    } sts_t;

endpackage

// ===== src/prja_ctrl.sv =====
// Controller state machine: table clear, item sequencing, divider steps, result hand-off.
`timescale 1ns / 1ps

module prja_ctrl
    import prja_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_tuser,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    priority if (s_tuser == ACT_SKIP)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (s_tuser == ACT_FINISH && !sts.total_zero)
                    begin
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_go   = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ROUND;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_ROUND:
            begin
                cmd.round_go = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// ===== src/prja_dp.sv =====
// Datapath: key table memory, window filter, saturating sums, share divider, output register.
`timescale 1ns / 1ps

module prja_dp
    import prja_pkg::*;
#(
    parameter int PART_KEYS = DEFAULT_PART_KEYS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic [1:0]             s_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [2:0]             m_tuser
);

    localparam int IDX_W     = $clog2(PART_KEYS);
    localparam int SPLIT_W   = 32;
    localparam int LO_PROD_W = SPLIT_W + PCT_W;
    localparam int HI_PROD_W = SUM_W - SPLIT_W + PCT_W;
    localparam logic [PCT_W-1:0] SCALE_C = PCT_W'(PCT_SCALE);

    logic [1:0] key_mem [PART_KEYS];

    logic [KEY_W-1:0]   in_key;
    logic               in_promo;

    logic [1:0]               action_reg;
    logic [KEY_W-1:0]         key_reg;
    logic                     promo_reg;
    logic signed [DAY_W-1:0]  ship_reg;
    logic [PRICE_W-1:0]       price_reg;
    logic [1:0]               entry_reg;
    logic [IDX_W-1:0]         clr_addr_reg;
    logic signed [DAY_W-1:0]  win_start_reg;
    logic signed [DAY_W-1:0]  win_end_reg;
    logic [SUM_W-1:0]         promo_sum_reg;
    logic [SUM_W-1:0]         promo_sum_next;
    logic [SUM_W-1:0]         total_sum_reg;
    logic [SUM_W-1:0]         total_sum_next;
    logic [DVD_W-1:0]         dvd_reg;
    logic [DVD_W-1:0]         dvd_next;
    logic [SUM_W-1:0]         rem_reg;
    logic [SUM_W-1:0]         rem_next;
    logic [PCT_W-1:0]         pct_reg;
    logic [PCT_W-1:0]         pct_next;
    logic                     m_valid_reg;
    logic [OUT_TDATA_W-1:0]   m_data_reg;
    logic [OUT_TDATA_W-1:0]   m_data_next;
    logic [2:0]               m_user_reg;
    logic [2:0]               m_user_next;

    logic                     key_ok;
    logic                     in_window;
    logic [SUM_W:0]           total_add;
    logic [SUM_W:0]           promo_add;
    logic [SUM_W:0]           rem_shift;
    logic [SUM_W:0]           rem_sub;
    logic                     rem_ge;
    logic                     half_up;
    logic [DVD_W:0]           q_round;
    logic [LO_PROD_W-1:0]     scale_lo;
    logic [HI_PROD_W-1:0]     scale_hi;
    logic [2:0]               status;
    logic [PCT_W-1:0]         pct_out;
    logic                     mem_we;
    logic [IDX_W-1:0]         mem_addr;
    logic [1:0]               mem_wdata;

    assign in_key   = s_tdata[KEY_LSB +: KEY_W];
    assign in_promo = (s_tdata[PREFIX_LSB +: PREFIX_W] == PROMO_WORD);

    assign key_ok    = !key_reg[KEY_W-1] && (key_reg < KEY_W'(PART_KEYS));
    assign in_window = (ship_reg >= win_start_reg) && (ship_reg < win_end_reg);

    // key table: single write port, registered read on item capture
    assign mem_we    = cmd.clr_step || (cmd.emit && action_reg == ACT_LOAD && key_ok);
    assign mem_addr  = cmd.clr_step ? clr_addr_reg : key_reg[IDX_W-1:0];
    assign mem_wdata = cmd.clr_step ? 2'b00 : {promo_reg, 1'b1};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            entry_reg <= key_mem[in_key[IDX_W-1:0]];
        end
    end

    // dividend = promo * scale, split into a 32x14 and a 31x14 partial product
    always_comb
    begin
        scale_lo = LO_PROD_W'(promo_sum_reg[SPLIT_W-1:0]) * LO_PROD_W'(SCALE_C);
        scale_hi = HI_PROD_W'(promo_sum_reg[SUM_W-1:SPLIT_W]) * HI_PROD_W'(SCALE_C);
    end

    // restoring division, one quotient bit per step
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub   = rem_shift - {1'b0, total_sum_reg};
        rem_ge    = (rem_shift >= {1'b0, total_sum_reg});
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        if (cmd.mul_go)
        begin
            rem_next = '0;
            dvd_next = DVD_W'(scale_lo) + {scale_hi, {SPLIT_W{1'b0}}};
        end
        else if (cmd.div_step)
        begin
            rem_next = rem_ge ? rem_sub[SUM_W-1:0] : rem_shift[SUM_W-1:0];
            dvd_next = {dvd_reg[DVD_W-2:0], rem_ge};
        end
    end

    always_comb
    begin
        half_up  = (rem_reg >= (total_sum_reg - rem_reg));
        q_round  = {1'b0, dvd_reg} + (DVD_W + 1)'(half_up);
        pct_next = pct_reg;
        if (cmd.round_go)
        begin
            pct_next = (q_round > (DVD_W + 1)'(PCT_SCALE)) ? PCT_W'(PCT_SCALE)
                                                            : q_round[PCT_W-1:0];
        end
    end

    // result and sum update
    always_comb
    begin
        total_add      = {1'b0, total_sum_reg} + (SUM_W + 1)'(price_reg);
        promo_add      = {1'b0, promo_sum_reg} + (SUM_W + 1)'(price_reg);
        status         = ST_COUNTED;
        pct_out        = '0;
        promo_sum_next = promo_sum_reg;
        total_sum_next = total_sum_reg;
        unique case (action_reg)
            ACT_LOAD:
            begin
                status = key_ok ? ST_COUNTED : ST_LOAD_RANGE;
            end
            ACT_LINE:
            begin
                priority if (!in_window)
                begin
                    status = ST_WINDOW;
                end
                else if (!key_ok || !entry_reg[ENTRY_VALID_BIT])
                begin
                    status = ST_UNKNOWN;
                end
                else
                begin
                    total_sum_next = total_add[SUM_W] ? SUM_MAX : total_add[SUM_W-1:0];
                    if (entry_reg[ENTRY_PROMO_BIT])
                    begin
                        promo_sum_next = promo_add[SUM_W] ? SUM_MAX
                                                          : promo_add[SUM_W-1:0];
                    end
                end
            end
            ACT_FINISH:
            begin
                status  = ST_REPORT;
                pct_out = (total_sum_reg == '0) ? '0 : pct_reg;
            end
            ACT_SKIP:
            begin
                status = ST_COUNTED;
            end
        endcase
        m_user_next = status;
        m_data_next = OUT_TDATA_W'({total_sum_next, promo_sum_next, pct_out});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= s_tuser;
            key_reg    <= in_key;
            promo_reg  <= in_promo;
            ship_reg   <= s_tdata[DAY_LSB +: DAY_W];
            price_reg  <= s_tdata[PRICE_LSB +: PRICE_W];
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        pct_reg <= pct_next;
        if (cmd.emit)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            win_start_reg <= '0;
            win_end_reg   <= '0;
            promo_sum_reg <= '0;
            total_sum_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_START: win_start_reg <= cfg_data;
                    REG_WINDOW_END:   win_end_reg   <= cfg_data;
                endcase
            end
            if (cmd.emit)
            begin
                if (action_reg == ACT_FINISH)
                begin
                    promo_sum_reg <= '0;
                    total_sum_reg <= '0;
                end
                else
                begin
                    promo_sum_reg <= promo_sum_next;
                    total_sum_reg <= total_sum_next;
                end
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.clr_last   = (clr_addr_reg == IDX_W'(PART_KEYS - 1));
    assign sts.total_zero = (total_sum_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== src/promo_revenue_join_aggregate.sv =====
// Top level of the promotion-revenue filter, join and aggregate block.
//
// Input stream (s_*): one word per item, s_tuser is the action (load part entry,
// line item, finish/report, or skip). Output stream (m_*): one result word per
// load, line or finish item; m_tuser is the status, m_tdata the share and sums.
// Config: cfg_we/cfg_index/cfg_data write window_start (0) and window_end (1),
// taken at any time but only meaningful while the block is idle.
// Reset: the key table is cleared one entry per cycle, all PART_KEYS entries,
// with s_tready low; sums and window registers reset to zero at once.
// Load and line items: capture with table read, then a result step that writes
// the output register; the next item is not taken before that step is done.
// Finish with a nonzero total: capture, a multiply, DIV_STEPS steps of the
// bit-serial share divider (one quotient bit per cycle), rounding, result.
// Skip items are taken and give no result.
// A stalled receiver holds the output register; the next item is accepted
// and worked on, and waits at its result step until the register frees.
`timescale 1ns / 1ps

module promo_revenue_join_aggregate
    import prja_pkg::*;
#(
    parameter int PART_KEYS = DEFAULT_PART_KEYS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: part_key[31:0], type_prefix[71:32], ship_day[87:72], price[118:88]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // s_tuser: action[1:0]
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: percent_hundredths[13:0], promo_total[76:14], grand_total[139:77]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]             m_tuser,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cmd_t cmd;
    sts_t sts;

    prja_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    prja_dp #(
        .PART_KEYS (PART_KEYS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
